// ----- rtl/core/agc_pkg.sv -----
// Shared types and constants of the audio AGC limiter.
package agc_pkg;

  // Operation codes carried in the input beat's tuser
  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_ADJUST = 2'd1,
    OP_RESET  = 2'd2,
    OP_NOP    = 2'd3
  } agc_op_t;

  // Configuration register indexes
  localparam logic CFG_SAMPLE_RATE   = 1'b0;
  localparam logic CFG_CHANNEL_COUNT = 1'b1;

  localparam int unsigned CFG_DATA_W   = 18;
  localparam int unsigned SAMPLE_W     = 32;
  localparam int unsigned VOLUME_W     = 16;
  localparam int unsigned COUNT_W      = 32;
  localparam int unsigned RATE_W       = 18;
  localparam int unsigned CHANNELS_W   = 4;
  localparam int unsigned IN_TDATA_W   = 64;

  // Scaled samples strictly beyond +/- this magnitude cut the gain
  localparam logic [31:0] AGC_LIMIT = 32'h0810_0000;

  // Register reset values
  localparam logic [RATE_W-1:0]     RATE_RESET     = 18'd44100;
  localparam logic [CHANNELS_W-1:0] CHANNELS_RESET = 4'd2;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_EVAL,
    ST_EOB,
    ST_DIV_INIT,
    ST_DIV,
    ST_ADJ_DONE,
    ST_GAIN_RST,
    ST_OUT
  } agc_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic mul;
    logic eval;
    logic eob;
    logic div_init;
    logic div_step;
    logic adj_done;
    logic gain_reset;
    logic out_load;
  } agc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last;
    logic newv_zero;
    logic div_last;
  } agc_sts_t;

endpackage

// ----- rtl/core/audio_agc_limiter.sv -----
// Audio AGC limiter top level: stream ports, controller and datapath.
//
// Each input beat yields one output beat. A sample beat runs the controller's
// sequence around one signed 33 x (GAIN_FRACTION_BITS+2) bit multiply and the
// limit compare, with an end-of-buffer step when it closes a buffer. A volume
// adjust beat runs a restoring divider one quotient bit per cycle, or skips
// the divider when the new volume is zero. The next input beat is taken once
// the previous result sits in the output register, even if that result has
// not yet been taken downstream.
module audio_agc_limiter #(
  parameter int GAIN_FRACTION_BITS = 10,
  parameter int SAMPLE_BITS        = 32
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  // tdata: sample_in[31:0], old_volume[47:32], new_volume[63:48]
  input  logic [agc_pkg::IN_TDATA_W-1:0]              in_tdata,
  // tuser: operation[1:0]
  input  logic [1:0]                                  in_tuser,
  input  logic                                        in_tlast,
  input  logic                                        in_tvalid,
  output logic                                        in_tready,
  // tdata: sample_out[31:0], gain_out[GAIN_FRACTION_BITS+32:32], zero fill
  output logic [((32+GAIN_FRACTION_BITS+1+7)/8)*8-1:0] out_tdata,
  // tuser: over_limit[0]
  output logic                                        out_tuser,
  output logic                                        out_tvalid,
  input  logic                                        out_tready,
  input  logic                                        cfg_we,
  input  logic                                        cfg_addr,
  input  logic [agc_pkg::CFG_DATA_W-1:0]              cfg_wdata
);
  import agc_pkg::*;

  localparam int OUT_W = ((32 + GAIN_FRACTION_BITS + 1 + 7) / 8) * 8;

  agc_cmd_t                  cmd;
  agc_sts_t                  sts;
  logic [SAMPLE_W-1:0]       out_sample;
  logic [GAIN_FRACTION_BITS:0] out_gain;

  // Sequencer
  agc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Arithmetic and state
  agc_datapath #(
    .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS),
    .SAMPLE_BITS        (SAMPLE_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_op      (in_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_sample (out_sample),
    .out_gain   (out_gain),
    .out_over   (out_tuser)
  );

  // Result beat packing
  assign out_tdata = OUT_W'({out_gain, out_sample});

endmodule

// ----- rtl/core/agc_ctrl.sv -----
// Sequencing state machine of the audio AGC limiter.
module agc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [1:0]          in_op,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  agc_pkg::agc_sts_t   sts,
  output agc_pkg::agc_cmd_t   cmd
);
  import agc_pkg::*;

  agc_state_t state_r, state_nxt;
  agc_op_t    op_r, op_nxt;
  logic       out_valid_r, out_valid_nxt;

  // State, operation and output valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_NOP;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    in_tready     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          op_nxt      = agc_op_t'(in_op);
          case (agc_op_t'(in_op))
            OP_SAMPLE: state_nxt = ST_MUL;
            OP_ADJUST: state_nxt = ST_MUL;
            OP_RESET:  state_nxt = ST_GAIN_RST;
            default:   state_nxt = ST_OUT;
          endcase
        end
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        if (op_r == OP_SAMPLE) begin
          state_nxt = ST_EVAL;
        end else if (sts.newv_zero) begin
          state_nxt = ST_ADJ_DONE;
        end else begin
          state_nxt = ST_DIV_INIT;
        end
      end
      ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = sts.last ? ST_EOB : ST_OUT;
      end
      ST_EOB: begin
        cmd.eob   = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_ADJ_DONE;
        end
      end
      ST_ADJ_DONE: begin
        cmd.adj_done = 1'b1;
        state_nxt    = ST_OUT;
      end
      ST_GAIN_RST: begin
        cmd.gain_reset = 1'b1;
        state_nxt      = ST_OUT;
      end
      ST_OUT: begin
        // result register free or being drained this cycle
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/agc_datapath.sv -----
// Datapath of the audio AGC limiter: multiplier, divider, gain and counters.
module agc_datapath #(
  parameter int GAIN_FRACTION_BITS = 10,
  parameter int SAMPLE_BITS        = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [agc_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                              in_tlast,
  input  logic [1:0]                        in_op,
  input  logic                              cfg_we,
  input  logic                              cfg_addr,
  input  logic [agc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  agc_pkg::agc_cmd_t                 cmd,
  output agc_pkg::agc_sts_t                 sts,
  output logic [agc_pkg::SAMPLE_W-1:0]      out_sample,
  output logic [GAIN_FRACTION_BITS:0]       out_gain,
  output logic                              out_over
);
  import agc_pkg::*;

  localparam int GW = GAIN_FRACTION_BITS + 1;        // gain width
  localparam int AW = SAMPLE_W + 1;                  // multiplier operand
  localparam int PW = AW + GW + 1;                   // product width
  localparam int VW = PW - GAIN_FRACTION_BITS;       // scaled sample width
  localparam int NW = GW + VOLUME_W;                 // dividend width
  localparam int CW = $clog2(NW);                    // divider step counter
  localparam logic [GW-1:0] UNITY = {1'b1, {GAIN_FRACTION_BITS{1'b0}}};
  localparam logic signed [VW-1:0] LIM_HI = VW'(AGC_LIMIT);
  localparam logic signed [VW-1:0] LIM_LO = -LIM_HI;

  // Configuration
  logic [RATE_W-1:0]     sample_rate_r;
  logic [CHANNELS_W-1:0] channel_count_r;

  // AGC state
  logic [GW-1:0]      gain_r, gain_nxt;
  logic [GW-1:0]      bsg_r, bsg_nxt;
  logic [COUNT_W-1:0] bcount_r, bcount_nxt;
  logic [COUNT_W-1:0] rec_r, rec_nxt;

  // Item payload and work registers
  logic signed [AW-1:0] op_a_r;
  logic                 last_r;
  logic [VOLUME_W-1:0]  newv_r;
  logic signed [PW-1:0] prod_r;
  logic [VOLUME_W-1:0]  rem_r;
  logic [NW-1:0]        q_r;
  logic [CW-1:0]        cnt_r;
  logic [SAMPLE_W-1:0]  res_sample_r;
  logic                 res_over_r;
  logic [SAMPLE_W-1:0]  out_sample_r;
  logic [GW-1:0]        out_gain_r;
  logic                 out_over_r;

  // Combinational helpers
  logic [SAMPLE_W-1:0]  smp_raw;
  logic signed [AW-1:0] smp_ext;
  logic signed [VW-1:0] val;
  logic                 over;
  logic [VOLUME_W:0]    rs;
  logic                 ge;
  logic [RATE_W-1:0]    tmo_full, tmo;
  logic [COUNT_W:0]     rec_sum;
  logic [COUNT_W-1:0]   rec_sat;
  logic                 recover;
  logic [GW-1:0]        adj_gain;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_rate_r   <= RATE_RESET;
      channel_count_r <= CHANNELS_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_SAMPLE_RATE:   sample_rate_r   <= cfg_wdata;
        CFG_CHANNEL_COUNT: channel_count_r <= cfg_wdata[CHANNELS_W-1:0];
        default:           sample_rate_r   <= sample_rate_r;
      endcase
    end
  end

  // Sign extension of the active sample bits
  assign smp_raw = in_tdata[SAMPLE_W-1:0];
  assign smp_ext = $signed({{(AW-SAMPLE_BITS){smp_raw[SAMPLE_BITS-1]}},
                            smp_raw[SAMPLE_BITS-1:0]});

  // Scaled sample and limit window
  assign val  = $signed(prod_r[PW-1:GAIN_FRACTION_BITS]);
  assign over = (val > LIM_HI) || (val < LIM_LO);

  // Restoring divider step
  assign rs = {rem_r, q_r[NW-1]};
  assign ge = rs >= {1'b0, newv_r};

  // Recovery timeout and accumulation
  assign tmo_full = sample_rate_r >> (GAIN_FRACTION_BITS - 8);
  assign tmo      = (channel_count_r < CHANNELS_W'(2)) ? (tmo_full >> 1) : tmo_full;
  assign rec_sum  = {1'b0, rec_r} + {1'b0, bcount_r};
  assign rec_sat  = rec_sum[COUNT_W] ? '1 : rec_sum[COUNT_W-1:0];
  assign recover  = (gain_r >= bsg_r) && (bsg_r < UNITY);

  // Adjust result clamped to unity
  assign adj_gain = (q_r > NW'(UNITY)) ? UNITY : q_r[GW-1:0];

  // Gain state update
  always_comb begin
    gain_nxt   = gain_r;
    bsg_nxt    = bsg_r;
    bcount_nxt = bcount_r;
    rec_nxt    = rec_r;
    if (cmd.eval) begin
      if (over && (gain_r != '0)) begin
        gain_nxt = gain_r - GW'(1);
      end
      if (bcount_r != '1) begin
        bcount_nxt = bcount_r + COUNT_W'(1);
      end
    end
    if (cmd.eob) begin
      if (recover) begin
        if (rec_sat >= COUNT_W'(tmo)) begin
          rec_nxt  = '0;
          gain_nxt = bsg_r + GW'(1);
        end else begin
          rec_nxt  = rec_sat;
          gain_nxt = bsg_r;
        end
      end else begin
        rec_nxt = '0;
      end
      bsg_nxt    = gain_nxt;
      bcount_nxt = '0;
    end
    if (cmd.adj_done) begin
      if (newv_r != '0) begin
        gain_nxt = adj_gain;
      end
      bsg_nxt    = gain_nxt;
      bcount_nxt = '0;
    end
    if (cmd.gain_reset) begin
      gain_nxt   = UNITY;
      bsg_nxt    = UNITY;
      bcount_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= UNITY;
      bsg_r    <= UNITY;
      bcount_r <= '0;
      rec_r    <= '0;
    end else begin
      gain_r   <= gain_nxt;
      bsg_r    <= bsg_nxt;
      bcount_r <= bcount_nxt;
      rec_r    <= rec_nxt;
    end
  end

  // Beat capture, multiplier, divider and result registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_a_r       <= (agc_op_t'(in_op) == OP_ADJUST) ?
                      $signed(AW'(in_tdata[SAMPLE_W +: VOLUME_W])) : smp_ext;
      newv_r       <= in_tdata[SAMPLE_W+VOLUME_W +: VOLUME_W];
      last_r       <= in_tlast;
      res_sample_r <= '0;
      res_over_r   <= 1'b0;
    end
    if (cmd.mul) begin
      prod_r <= op_a_r * $signed({1'b0, gain_r});
    end
    if (cmd.eval) begin
      res_sample_r <= val[SAMPLE_W-1:0];
      res_over_r   <= over;
    end
    if (cmd.div_init) begin
      rem_r <= '0;
      q_r   <= prod_r[NW-1:0];
      cnt_r <= CW'(NW - 1);
    end
    if (cmd.div_step) begin
      rem_r <= ge ? VOLUME_W'(rs - {1'b0, newv_r}) : rs[VOLUME_W-1:0];
      q_r   <= {q_r[NW-2:0], ge};
      cnt_r <= cnt_r - CW'(1);
    end
    if (cmd.out_load) begin
      out_sample_r <= res_sample_r;
      out_gain_r   <= gain_r;
      out_over_r   <= res_over_r;
    end
  end

  assign sts.last      = last_r;
  assign sts.newv_zero = (newv_r == '0);
  assign sts.div_last  = (cnt_r == '0);

  assign out_sample = out_sample_r;
  assign out_gain   = out_gain_r;
  assign out_over   = out_over_r;

endmodule
